FILE: rtl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// Sequencer state, region phase, multiplier operand select and the control/status structs.
// No dependencies.
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 9;
  localparam int COORD_BITS_DEF  = 10;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SLY,
    ST_INIT,
    ST_CHK,
    ST_TT,
    ST_TA,
    ST_UU,
    ST_UB,
    ST_RR,
    ST_FIN,
    ST_EMIT,
    ST_ADV
  } state_t;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_R1,
    PH_R2
  } phase_t;

  typedef enum logic [2:0] {
    MS_RX,
    MS_RY,
    MS_RX2_RY,
    MS_TT,
    MS_RY2_P,
    MS_UU,
    MS_RX2_P,
    MS_RX2_RY2
  } msel_t;

  typedef struct packed {
    logic  idle;
    logic  take;
    logic  cap_rx2;
    logic  cap_ry2;
    logic  init;
    logic  acc_load;
    logic  acc_add;
    logic  acc_fin;
    logic  emit;
    logic  adv;
    msel_t msel;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic in_restart;
    logic restart;
    logic active;
    logic settle;
    logic pend;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/mer_mul.sv
// Shared signed multiplier with registered product.
// Operands are selected by the datapath; the product is valid in the cycle after issue.
// Depends on nothing.
module mer_mul #(
  parameter int A_W = 24,
  parameter int B_W = 19
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/mer_ctrl.sv
// Sequencer for the midpoint ellipse rasterizer.
// Walks squares, region-1 seed, region-2 seed, emit and step; uses mer_pkg types.
module mer_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  mer_pkg::sts_t sts,
  output mer_pkg::ctl_t ctl
);
  import mer_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.in_valid && (sts.in_restart || sts.active)) state_next = ST_SQX;
      end
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = ST_SLY;
      ST_SLY: state_next = sts.restart ? ST_INIT : ST_EMIT;
      ST_INIT: state_next = ST_CHK;
      ST_CHK: begin
        if (sts.settle) state_next = ST_TT;
        else if (sts.pend) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_TT: state_next = ST_TA;
      ST_TA: state_next = ST_UU;
      ST_UU: state_next = ST_UB;
      ST_UB: state_next = ST_RR;
      ST_RR: state_next = ST_FIN;
      ST_FIN: state_next = sts.pend ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!sts.out_busy) state_next = sts.last ? ST_IDLE : ST_ADV;
      end
      ST_ADV: state_next = ST_CHK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.msel = MS_RX;
    case (state)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        ctl.take = sts.in_valid;
      end
      ST_SQX: ctl.msel = MS_RX;
      ST_SQY: begin
        ctl.cap_rx2 = 1'b1;
        ctl.msel = MS_RY;
      end
      ST_SLY: begin
        ctl.cap_ry2 = 1'b1;
        ctl.msel = MS_RX2_RY;
      end
      ST_INIT: ctl.init = 1'b1;
      ST_CHK: ctl.msel = MS_TT;
      ST_TT: ctl.msel = MS_TT;
      ST_TA: ctl.msel = MS_RY2_P;
      ST_UU: begin
        ctl.acc_load = 1'b1;
        ctl.msel = MS_UU;
      end
      ST_UB: ctl.msel = MS_RX2_P;
      ST_RR: begin
        ctl.acc_add = 1'b1;
        ctl.msel = MS_RX2_RY2;
      end
      ST_FIN: ctl.acc_fin = 1'b1;
      ST_EMIT: ctl.emit = !sts.out_busy;
      ST_ADV: ctl.adv = 1'b1;
      default: ctl.idle = 1'b0;
    endcase
  end

endmodule

FILE: rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer, top level: configuration, datapath registers and output stage.
// Uses mer_pkg, mer_mul (shared multiplier) and mer_ctrl (sequencer).
// One transaction with restart high starts an ellipse at offset (0, radius_y) and returns
// its first point; one with restart low returns the next point, or nothing once the last
// point (flagged by last_point) has gone out. Each point carries the four mirrored
// coordinates modulo 2^(COORD_BITS+2). All products go through one registered multiplier,
// one per cycle. An advance squares the radii, forms the slope product, emits its point
// and then steps and checks for the next; a restart squares the radii, forms the slope
// product, seeds region 1 and checks before it emits; a point that crosses into region 2
// adds the seed products. An advance with no ellipse active is taken while idle and gives
// nothing. in_stall is high while a transaction is in work; the output register holds a
// result until it is taken, and a new point waits while it is full.
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  localparam int CFG_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS,
  localparam int OUT_W = COORD_BITS + 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             restart,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [OUT_W-1:0]          x_right,
  output logic signed [OUT_W-1:0]          x_left,
  output logic signed [OUT_W-1:0]          y_below,
  output logic signed [OUT_W-1:0]          y_above,
  output logic                             last_point
);
  import mer_pkg::*;

  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int OFF_W = RADIUS_BITS + 1;
  localparam int T_W   = OFF_W + 2;
  localparam int U_W   = OFF_W + 1;
  localparam int A_W   = 2 * OFF_W + 4;
  localparam int B_W   = SQ_W + 1;
  localparam int P_W   = A_W + B_W;
  localparam int SLP_W = SQ_W + OFF_W + 2;
  localparam int DEC_W = P_W + 3;

  logic [COORD_BITS-1:0]   cx, cy;
  logic [RADIUS_BITS-1:0]  rx, ry;
  logic [SQ_W-1:0]         rx2, ry2;
  logic [OFF_W-1:0]        x, y;
  logic signed [SLP_W-1:0] slx, sly;
  logic signed [DEC_W-1:0] dec;
  phase_t                  phase;
  logic                    restart_q, pend;

  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   p;

  ctl_t ctl;
  sts_t sts;

  logic signed [T_W-1:0]   t_val;
  logic signed [U_W-1:0]   u_val;
  logic signed [DEC_W-1:0] p_d, rx2_d, ry2_d, slx_nd, sly_nd;
  logic signed [SLP_W-1:0] slx_inc, sly_dec;
  logic [OFF_W-1:0]        x_adv, y_adv;
  logic signed [SLP_W-1:0] slx_adv, sly_adv;
  logic signed [DEC_W-1:0] dec_adv;
  logic                    last;

  assign t_val = {1'b0, x, 1'b1};
  assign u_val = {1'b0, y} - U_W'(1);
  assign p_d   = DEC_W'(p);
  assign rx2_d = DEC_W'(rx2);
  assign ry2_d = DEC_W'(ry2);
  assign last  = (phase == PH_R2) && (y == '0);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = A_W'(rx);
    mul_b = B_W'(rx);
    case (ctl.msel)
      MS_RX: begin
        mul_a = A_W'(rx);
        mul_b = B_W'(rx);
      end
      MS_RY: begin
        mul_a = A_W'(ry);
        mul_b = B_W'(ry);
      end
      MS_RX2_RY: begin
        mul_a = A_W'(ry);
        mul_b = B_W'(rx2);
      end
      MS_TT: begin
        mul_a = A_W'(t_val);
        mul_b = B_W'(t_val);
      end
      MS_RY2_P: begin
        mul_a = p[A_W-1:0];
        mul_b = B_W'(ry2);
      end
      MS_UU: begin
        mul_a = A_W'(u_val);
        mul_b = B_W'(u_val);
      end
      MS_RX2_P: begin
        mul_a = p[A_W-1:0];
        mul_b = B_W'(rx2);
      end
      MS_RX2_RY2: begin
        mul_a = A_W'(ry2);
        mul_b = B_W'(rx2);
      end
      default: begin
        mul_a = A_W'(rx);
        mul_b = B_W'(rx);
      end
    endcase
  end

  mer_mul #(
    .A_W(A_W),
    .B_W(B_W)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (p)
  );

  // one step of the decision recurrence
  assign slx_inc = slx + SLP_W'({ry2, 1'b0});
  assign sly_dec = sly - SLP_W'({rx2, 1'b0});
  assign slx_nd  = DEC_W'(slx_inc);
  assign sly_nd  = DEC_W'(sly_dec);

  always_comb begin
    x_adv   = x;
    y_adv   = y;
    slx_adv = slx;
    sly_adv = sly;
    dec_adv = dec;
    case (phase)
      PH_R1: begin
        x_adv   = x + OFF_W'(1);
        slx_adv = slx_inc;
        if (dec[DEC_W-1]) begin
          dec_adv = dec + ((slx_nd + ry2_d) <<< 2);
        end else begin
          y_adv   = y - OFF_W'(1);
          sly_adv = sly_dec;
          dec_adv = dec + ((slx_nd - sly_nd + ry2_d) <<< 2);
        end
      end
      PH_R2: begin
        y_adv   = y - OFF_W'(1);
        sly_adv = sly_dec;
        if (!dec[DEC_W-1] && (dec != '0)) begin
          dec_adv = dec + ((rx2_d - sly_nd) <<< 2);
        end else begin
          x_adv   = x + OFF_W'(1);
          slx_adv = slx_inc;
          dec_adv = dec + ((slx_nd - sly_nd + rx2_d) <<< 2);
        end
      end
      default: dec_adv = dec;
    endcase
  end

  assign sts.in_valid   = in_valid;
  assign sts.in_restart = restart;
  assign sts.restart    = restart_q;
  assign sts.active     = (phase != PH_DONE);
  assign sts.settle     = (phase == PH_R1) && !(slx < sly);
  assign sts.pend       = pend;
  assign sts.last       = last;
  assign sts.out_busy   = out_valid && out_stall;

  mer_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .ctl(ctl)
  );

  assign in_stall = !ctl.idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      rx <= '0;
      ry <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cx <= cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Y: cy <= cfg_data[COORD_BITS-1:0];
        CFG_RADIUS_X: rx <= cfg_data[RADIUS_BITS-1:0];
        CFG_RADIUS_Y: ry <= cfg_data[RADIUS_BITS-1:0];
        default: cx <= cx;
      endcase
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      restart_q <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.take) begin
        restart_q <= restart;
        pend      <= 1'b1;
      end
      if (ctl.init) phase <= PH_R1;
      if (ctl.acc_fin) phase <= PH_R2;
      if (ctl.emit) begin
        pend <= 1'b0;
        if (last) phase <= PH_DONE;
      end
      if (ctl.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.cap_rx2) rx2 <= p[SQ_W-1:0];
    if (ctl.cap_ry2) ry2 <= p[SQ_W-1:0];
    if (ctl.init) begin
      x   <= '0;
      y   <= OFF_W'(ry);
      slx <= '0;
      sly <= {p[SLP_W-2:0], 1'b0};
      dec <= (ry2_d <<< 2) - (p_d <<< 2) + rx2_d;
    end
    if (ctl.acc_load) dec <= p_d;
    if (ctl.acc_add) dec <= dec + (p_d <<< 2);
    if (ctl.acc_fin) dec <= dec - (p_d <<< 2);
    if (ctl.adv) begin
      x   <= x_adv;
      y   <= y_adv;
      slx <= slx_adv;
      sly <= sly_adv;
      dec <= dec_adv;
    end
    if (ctl.emit) begin
      x_right    <= OUT_W'(cx) + OUT_W'(x);
      x_left     <= OUT_W'(cx) - OUT_W'(x);
      y_below    <= OUT_W'(cy) + OUT_W'(y);
      y_above    <= OUT_W'(cy) - OUT_W'(y);
      last_point <= last;
    end
  end

endmodule
